// File: design/multi_slot_watchdog_bank_macros.svh
// Assertion macros used by the watchdog bank datapath.
`ifndef MULTI_SLOT_WATCHDOG_BANK_MACROS_SVH
`define MULTI_SLOT_WATCHDOG_BANK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MSWB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSWB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/mswb_pkg.sv
// Shared types and constants for the multi-slot watchdog bank.
`timescale 1ns / 1ps

package mswb_pkg;

   // Number of watchdog slots in the bank.
   localparam int SLOTS = 16;

   // Width of a slot index and of the registered-slot count.
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);

   // Field widths fixed by the interface.
   localparam int TICK_W     = 32;
   localparam int REQ_SLOT_W = 4;
   localparam int RSP_SLOT_W = 4;

   // Width used to compare a requested slot with the registered count.
   localparam int CMP_W = (CNT_W > REQ_SLOT_W) ? CNT_W : REQ_SLOT_W;

   // Request codes.
   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_REGISTER = 2'd1,
      REQ_DISABLE  = 2'd2,
      REQ_KICK     = 2'd3
   } req_code_type;

   // Result kinds.
   typedef enum logic [2:0] {
      KIND_DONE       = 3'd0,
      KIND_EXPIRED    = 3'd1,
      KIND_REGISTERED = 3'd2,
      KIND_FULL       = 3'd3,
      KIND_BAD        = 3'd4
   } kind_code_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FINAL
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the request word
      logic tick_inc;    // advance the tick counter
      logic scan_clear;  // point the scan at slot zero
      logic scan_next;   // advance the scan to the next slot
      logic scan_check;  // test the current slot for expiry
      logic exec;        // carry out a register, disable or kick request
      logic finish;      // emit the closing done word of a tick
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic bank_empty;  // no slot registered yet
      logic scan_last;   // scan sits on the highest registered slot
   } ctrl_status_type;

endpackage

// File: design/multi_slot_watchdog_bank.sv
// Top level of the multi-slot watchdog bank.
`timescale 1ns / 1ps
// A bank of watchdog slots that share one 32-bit wrapping tick counter.
// Request channel: a word is taken at a rising edge with start high and
// busy low; req_type selects tick, register, disable or kick.
// Result channel: each result word is on the rsp_ ports for one cycle,
// marked by rsp_valid; rsp_last_result marks the final word of a request.
// Register, disable and kick requests pass through the EXEC state and give
// one word from the result register; the block is busy in EXEC and takes the
// next request in the cycle the result is shown.
// A tick runs the SCAN state over the registered slots, then the FINAL state
// (straight to FINAL when none is registered): the scan visits one slot per
// cycle through the registered read port of the slot tables, emitting an
// expiry word for each slot that runs out, and FINAL emits a closing done word.
// Reset clears the tick counter, the slot count and all enable bits; the
// slot tables need no clearing since only registered slots are ever checked.
// Results cannot be held off by the receiver, so none is ever stalled.
module multi_slot_watchdog_bank (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_type,
   input  logic [mswb_pkg::REQ_SLOT_W-1:0]      req_slot_index,
   input  logic [mswb_pkg::TICK_W-1:0]          req_timeout_ticks,
   input  logic                                 req_start_disabled,
   output logic                                 rsp_valid,
   output logic [2:0]                           rsp_result_kind,
   output logic [mswb_pkg::RSP_SLOT_W-1:0]      rsp_result_slot,
   output logic                                 rsp_last_result
);

   mswb_pkg::ctrl_cmd_type    cmd;
   mswb_pkg::ctrl_status_type status;

   // Sequencing of requests and of the expiry scan.
   mswb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Counter, slot tables and result register.
   mswb_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_type           (req_type),
      .req_slot_index     (req_slot_index),
      .req_timeout_ticks  (req_timeout_ticks),
      .req_start_disabled (req_start_disabled),
      .rsp_valid          (rsp_valid),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_result_slot    (rsp_result_slot),
      .rsp_last_result    (rsp_last_result)
   );

endmodule

// File: design/mswb_ctrl.sv
// Controller state machine that sequences requests and the expiry scan.
`timescale 1ns / 1ps

module mswb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                req_type,
   input  mswb_pkg::ctrl_status_type status,
   output mswb_pkg::ctrl_cmd_type    cmd,
   output logic                      busy
);

   mswb_pkg::state_type state_ff;
   mswb_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mswb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != mswb_pkg::ST_IDLE);
      case (state_ff)
         mswb_pkg::ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               if (req_type == mswb_pkg::REQ_TICK) begin
                  cmd.tick_inc   = 1'b1;
                  cmd.scan_clear = 1'b1;
                  state_in = status.bank_empty ? mswb_pkg::ST_FINAL : mswb_pkg::ST_SCAN;
               end else begin
                  state_in = mswb_pkg::ST_EXEC;
               end
            end
         end
         mswb_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = mswb_pkg::ST_IDLE;
         end
         mswb_pkg::ST_SCAN: begin
            cmd.scan_check = 1'b1;
            if (status.scan_last) begin
               state_in = mswb_pkg::ST_FINAL;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         mswb_pkg::ST_FINAL: begin
            cmd.finish = 1'b1;
            state_in   = mswb_pkg::ST_IDLE;
         end
         default: begin
            state_in = mswb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: design/mswb_datapath.sv
// Datapath: tick counter, slot tables, enable bits and the result register.
`timescale 1ns / 1ps
`include "multi_slot_watchdog_bank_macros.svh"

module mswb_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mswb_pkg::ctrl_cmd_type               cmd,
   output mswb_pkg::ctrl_status_type            status,
   input  logic [1:0]                           req_type,
   input  logic [mswb_pkg::REQ_SLOT_W-1:0]      req_slot_index,
   input  logic [mswb_pkg::TICK_W-1:0]          req_timeout_ticks,
   input  logic                                 req_start_disabled,
   output logic                                 rsp_valid,
   output logic [2:0]                           rsp_result_kind,
   output logic [mswb_pkg::RSP_SLOT_W-1:0]      rsp_result_slot,
   output logic                                 rsp_last_result
);

   // Request word held for the duration of the request.
   mswb_pkg::req_code_type                 req_code_ff, req_code_in;
   logic [mswb_pkg::REQ_SLOT_W-1:0]        slot_index_ff, slot_index_in;
   logic [mswb_pkg::TICK_W-1:0]            timeout_ff, timeout_in;
   logic                                   start_disabled_ff, start_disabled_in;

   // Bank state.
   logic [mswb_pkg::TICK_W-1:0]            tick_ff, tick_in;
   logic [mswb_pkg::CNT_W-1:0]             used_ff, used_in;
   logic [mswb_pkg::SLOTS-1:0]             enable_ff, enable_in;
   logic [mswb_pkg::SLOT_W-1:0]            scan_idx_ff, scan_idx_in;

   // Slot tables and their registered read data.
   logic [mswb_pkg::TICK_W-1:0]            start_mem [mswb_pkg::SLOTS];
   logic [mswb_pkg::TICK_W-1:0]            timeout_mem [mswb_pkg::SLOTS];
   logic [mswb_pkg::TICK_W-1:0]            start_rd_ff;
   logic [mswb_pkg::TICK_W-1:0]            timeout_rd_ff;

   // Table write port.
   logic                                   start_we;
   logic                                   timeout_we;
   logic [mswb_pkg::SLOT_W-1:0]            wr_addr;

   // Result register.
   logic                                   rsp_valid_ff, rsp_valid_in;
   mswb_pkg::kind_code_type                rsp_kind_ff, rsp_kind_in;
   logic [mswb_pkg::RSP_SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic                                   rsp_last_ff, rsp_last_in;

   // Decoded conditions.
   logic                                   bank_full;
   logic                                   slot_bad;
   logic [mswb_pkg::SLOT_W-1:0]            req_slot;
   logic [mswb_pkg::SLOT_W-1:0]            new_slot;
   logic [mswb_pkg::TICK_W-1:0]            elapsed;
   logic                                   expired;

   assign bank_full = (used_ff == mswb_pkg::CNT_W'(mswb_pkg::SLOTS));
   assign slot_bad  = (mswb_pkg::CMP_W'(slot_index_ff) >= mswb_pkg::CMP_W'(used_ff));
   assign req_slot  = mswb_pkg::SLOT_W'(slot_index_ff);
   assign new_slot  = used_ff[mswb_pkg::SLOT_W-1:0];
   assign elapsed   = tick_ff - start_rd_ff;
   assign expired   = enable_ff[scan_idx_ff] && (elapsed > timeout_rd_ff);

   assign status.bank_empty = (used_ff == '0);
   assign status.scan_last  =
      ((mswb_pkg::CNT_W'(scan_idx_ff) + mswb_pkg::CNT_W'(1)) == used_ff);

   // Next-state logic for counters, enables, table writes and the result word.
   always_comb begin
      req_code_in       = req_code_ff;
      slot_index_in     = slot_index_ff;
      timeout_in        = timeout_ff;
      start_disabled_in = start_disabled_ff;
      tick_in           = tick_ff;
      used_in           = used_ff;
      enable_in         = enable_ff;
      scan_idx_in       = scan_idx_ff;
      start_we          = 1'b0;
      timeout_we        = 1'b0;
      wr_addr           = req_slot;
      rsp_valid_in      = 1'b0;
      rsp_kind_in       = mswb_pkg::KIND_DONE;
      rsp_slot_in       = '0;
      rsp_last_in       = 1'b1;

      if (cmd.capture) begin
         req_code_in       = mswb_pkg::req_code_type'(req_type);
         slot_index_in     = req_slot_index;
         timeout_in        = req_timeout_ticks;
         start_disabled_in = req_start_disabled;
      end

      if (cmd.tick_inc) begin
         tick_in = tick_ff + mswb_pkg::TICK_W'(1);
      end

      if (cmd.scan_clear) begin
         scan_idx_in = '0;
      end else if (cmd.scan_next) begin
         scan_idx_in = scan_idx_ff + mswb_pkg::SLOT_W'(1);
      end

      // Expiry of the slot under the scan.
      if (cmd.scan_check && expired) begin
         enable_in[scan_idx_ff] = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_kind_in  = mswb_pkg::KIND_EXPIRED;
         rsp_slot_in  = mswb_pkg::RSP_SLOT_W'(scan_idx_ff);
         rsp_last_in  = 1'b0;
      end

      // Closing word of a tick.
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = mswb_pkg::KIND_DONE;
         rsp_slot_in  = '0;
         rsp_last_in  = 1'b1;
      end

      // Register, disable and kick requests.
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         case (req_code_ff)
            mswb_pkg::REQ_REGISTER: begin
               if (bank_full) begin
                  rsp_kind_in = mswb_pkg::KIND_FULL;
                  rsp_slot_in = '0;
               end else begin
                  wr_addr             = new_slot;
                  start_we            = 1'b1;
                  timeout_we          = 1'b1;
                  enable_in[new_slot] = !start_disabled_ff;
                  used_in             = used_ff + mswb_pkg::CNT_W'(1);
                  rsp_kind_in         = mswb_pkg::KIND_REGISTERED;
                  rsp_slot_in         = mswb_pkg::RSP_SLOT_W'(used_ff);
               end
            end
            mswb_pkg::REQ_DISABLE, mswb_pkg::REQ_KICK: begin
               rsp_slot_in = slot_index_ff;
               if (slot_bad) begin
                  rsp_kind_in = mswb_pkg::KIND_BAD;
               end else begin
                  rsp_kind_in = mswb_pkg::KIND_DONE;
                  if (req_code_ff == mswb_pkg::REQ_KICK) begin
                     start_we            = 1'b1;
                     enable_in[req_slot] = 1'b1;
                  end else begin
                     enable_in[req_slot] = 1'b0;
                  end
               end
            end
            default: begin
               rsp_kind_in = mswb_pkg::KIND_DONE;
               rsp_slot_in = '0;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         used_ff      <= '0;
         enable_ff    <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tick_ff      <= tick_in;
         used_ff      <= used_in;
         enable_ff    <= enable_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_code_ff       <= req_code_in;
      slot_index_ff     <= slot_index_in;
      timeout_ff        <= timeout_in;
      start_disabled_ff <= start_disabled_in;
      rsp_kind_ff       <= rsp_kind_in;
      rsp_slot_ff       <= rsp_slot_in;
      rsp_last_ff       <= rsp_last_in;
   end

   // Slot tables: one write port, one registered read port that follows the scan.
   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem[wr_addr] <= tick_ff;
      end
      if (timeout_we) begin
         timeout_mem[wr_addr] <= timeout_ff;
      end
      start_rd_ff   <= start_mem[scan_idx_in];
      timeout_rd_ff <= timeout_mem[scan_idx_in];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_last_result = rsp_last_ff;

   // The registered-slot count never passes the bank size.
   `MSWB_ASSERT_IMPL(a_used_bound, clock, reset, 1'b1, used_ff <= mswb_pkg::CNT_W'(mswb_pkg::SLOTS), "slot count above bank size")
   // An expiry word is never the final word of a tick.
   `MSWB_ASSERT_IMPL(a_expiry_not_last, clock, reset, rsp_valid_ff && (rsp_kind_ff == mswb_pkg::KIND_EXPIRED), !rsp_last_ff, "expiry word marked last")
   // A tick request advances the counter by exactly one.
   `MSWB_ASSERT_NEXT(a_tick_step, clock, reset, cmd.tick_inc, tick_ff == ($past(tick_ff) + mswb_pkg::TICK_W'(1)), "tick counter did not advance by one")
   // A slot that expires is disabled on the next cycle.
   `MSWB_ASSERT_NEXT(a_expiry_disables, clock, reset, cmd.scan_check && expired, !enable_ff[$past(scan_idx_ff)], "expired slot still enabled")

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the multi-slot watchdog bank: directed and random requests.
`timescale 1ns / 1ps

module tb_top;

   // One request word as the driver presents it.
   typedef struct {
      mswb_pkg::req_code_type code;
      logic [3:0]             slot;
      logic [31:0]            timeout;
      logic                   hold_off;
   } bank_req_type;

   // One result word as the bank should show it.
   typedef struct {
      mswb_pkg::kind_code_type kind;
      logic [3:0]              slot;
      logic                    last;
   } result_word_type;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        start              = 1'b0;
   logic        busy;
   logic [1:0]  req_type           = mswb_pkg::REQ_TICK;
   logic [3:0]  req_slot_index     = '0;
   logic [31:0] req_timeout_ticks  = '0;
   logic        req_start_disabled = 1'b0;
   logic        rsp_valid;
   logic [2:0]  rsp_result_kind;
   logic [3:0]  rsp_result_slot;
   logic        rsp_last_result;

   multi_slot_watchdog_bank u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_slot_index     (req_slot_index),
      .req_timeout_ticks  (req_timeout_ticks),
      .req_start_disabled (req_start_disabled),
      .rsp_valid          (rsp_valid),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_result_slot    (rsp_result_slot),
      .rsp_last_result    (rsp_last_result)
   );

   // Shadow copy of the bank state, advanced once per accepted word.
   logic [31:0] tick_now                      = '0;
   int unsigned slot_count                    = 0;
   logic [31:0] armed_at [mswb_pkg::SLOTS]    = '{default: '0};
   logic [31:0] limit_of [mswb_pkg::SLOTS]    = '{default: '0};
   logic        live     [mswb_pkg::SLOTS]    = '{default: 1'b0};

   result_word_type due_words[$];
   bank_req_type    req_backlog[$];
   bank_req_type    in_flight;
   bit              holding = 1'b0;

   int unsigned accepted      = 0;
   int unsigned words_checked = 0;
   int unsigned expiries_seen = 0;
   int unsigned fulls_seen    = 0;
   int unsigned bad_seen      = 0;
   int unsigned mismatches    = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void note_due(mswb_pkg::kind_code_type k, logic [3:0] s, logic l);
      result_word_type w;
      w.kind = k;
      w.slot = s;
      w.last = l;
      due_words.push_back(w);
   endfunction

   // Apply one request to the shadow bank and queue the words it must produce.
   function automatic void apply_request_to_bank(bank_req_type r);
      logic [31:0] elapsed;
      int unsigned i;
      case (r.code)
         mswb_pkg::REQ_TICK: begin
            tick_now = tick_now + 32'd1;
            for (i = 0; i < slot_count; i++) begin
               elapsed = tick_now - armed_at[i];
               if (live[i] && elapsed > limit_of[i]) begin
                  live[i] = 1'b0;
                  note_due(mswb_pkg::KIND_EXPIRED, 4'(i), 1'b0);
               end
            end
            note_due(mswb_pkg::KIND_DONE, 4'd0, 1'b1);
         end
         mswb_pkg::REQ_REGISTER: begin
            if (slot_count < mswb_pkg::SLOTS) begin
               armed_at[slot_count] = tick_now;
               limit_of[slot_count] = r.timeout;
               live[slot_count]     = !r.hold_off;
               note_due(mswb_pkg::KIND_REGISTERED, 4'(slot_count), 1'b1);
               slot_count++;
            end else begin
               note_due(mswb_pkg::KIND_FULL, 4'd0, 1'b1);
            end
         end
         default: begin
            // Disable and kick only act on slots that are registered.
            if (r.slot >= slot_count) begin
               note_due(mswb_pkg::KIND_BAD, r.slot, 1'b1);
            end else begin
               if (r.code == mswb_pkg::REQ_DISABLE) begin
                  live[r.slot] = 1'b0;
               end else begin
                  armed_at[r.slot] = tick_now;
                  live[r.slot]     = 1'b1;
               end
               note_due(mswb_pkg::KIND_DONE, r.slot, 1'b1);
            end
         end
      endcase
   endfunction

   function automatic void queue_req(mswb_pkg::req_code_type c, logic [3:0] s,
                                     logic [31:0] t, logic h);
      bank_req_type r;
      r.code     = c;
      r.slot     = s;
      r.timeout  = t;
      r.hold_off = h;
      req_backlog.push_back(r);
   endfunction

   // Request driver: a word is taken when start is high and busy is low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_request_to_bank(in_flight);
            accepted++;
            holding = 1'b0;
         end
         // Random gaps, except for a long stretch in the middle of the run.
         if (!holding && req_backlog.size() != 0 &&
             ((accepted >= 120 && accepted < 200) || $urandom_range(99) >= 12)) begin
            in_flight = req_backlog.pop_front();
            holding   = 1'b1;
         end
         start              <= holding;
         req_type           <= in_flight.code;
         req_slot_index     <= in_flight.slot;
         req_timeout_ticks  <= in_flight.timeout;
         req_start_disabled <= in_flight.hold_off;
      end
   end

   // Result monitor: every strobed word is checked against the oldest expectation.
   always @(posedge clock) begin
      result_word_type want;
      if (!reset && rsp_valid) begin
         if (due_words.size() == 0) begin
            $error("unexpected result word: kind %0d slot %0d last %0d",
                   rsp_result_kind, rsp_result_slot, rsp_last_result);
            mismatches++;
         end else begin
            want = due_words.pop_front();
            if (rsp_result_kind !== want.kind) begin
               $error("result_kind: expected %0d, got %0d", want.kind, rsp_result_kind);
               mismatches++;
            end
            if (rsp_result_slot !== want.slot) begin
               $error("result_slot: expected %0d, got %0d", want.slot, rsp_result_slot);
               mismatches++;
            end
            if (rsp_last_result !== want.last) begin
               $error("last_result: expected %0d, got %0d", want.last, rsp_last_result);
               mismatches++;
            end
            words_checked++;
            if (want.kind == mswb_pkg::KIND_EXPIRED) expiries_seen++;
            if (want.kind == mswb_pkg::KIND_FULL) fulls_seen++;
            if (want.kind == mswb_pkg::KIND_BAD) bad_seen++;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int unsigned gen_used;
      int unsigned roll;
      int unsigned reg_weight;
      int unsigned n;
      int unsigned guard;
      logic [3:0]  pick;
      logic [31:0] tmo;

      // Directed: empty bank, bad slots, timeout extremes, disabled start, expiries.
      queue_req(mswb_pkg::REQ_TICK,     4'd0,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_DISABLE,  4'd0,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_KICK,     4'd15, 32'hFFFF_FFFF,  1'b1);
      queue_req(mswb_pkg::REQ_REGISTER, 4'd0,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_REGISTER, 4'd0,  32'hFFFF_FFFF,  1'b1);
      queue_req(mswb_pkg::REQ_REGISTER, 4'd0,  32'd1,          1'b0);
      queue_req(mswb_pkg::REQ_KICK,     4'd3,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_TICK,     4'd0,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_TICK,     4'd0,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_KICK,     4'd1,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_DISABLE,  4'd0,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_KICK,     4'd2,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_DISABLE,  4'd2,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_TICK,     4'd0,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_REGISTER, 4'd0,  32'h8000_0000,  1'b0);
      queue_req(mswb_pkg::REQ_REGISTER, 4'd0,  32'h7FFF_FFFF,  1'b1);
      queue_req(mswb_pkg::REQ_KICK,     4'd0,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_TICK,     4'd0,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_TICK,     4'd0,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_DISABLE,  4'd1,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_KICK,     4'd4,  32'd0,          1'b0);
      queue_req(mswb_pkg::REQ_TICK,     4'd0,  32'd0,          1'b0);
      gen_used = 5;

      // Random: mostly valid slots and short timeouts so that slots keep expiring.
      for (n = 0; n < 258; n++) begin
         roll       = $urandom_range(99);
         reg_weight = (gen_used < mswb_pkg::SLOTS) ? 20 : 5;
         if (gen_used > 0 && $urandom_range(99) < 85) begin
            pick = 4'($urandom_range(gen_used - 1));
         end else begin
            pick = 4'($urandom_range(15));
         end
         tmo = ($urandom_range(99) < 70) ? 32'($urandom_range(12)) : 32'($urandom);
         if (roll < reg_weight) begin
            queue_req(mswb_pkg::REQ_REGISTER, pick, tmo, 1'($urandom_range(1)));
            if (gen_used < mswb_pkg::SLOTS) gen_used++;
         end else if (roll < reg_weight + 40) begin
            queue_req(mswb_pkg::REQ_TICK, pick, tmo, 1'($urandom_range(1)));
         end else if (roll < reg_weight + 52) begin
            queue_req(mswb_pkg::REQ_DISABLE, pick, tmo, 1'($urandom_range(1)));
         end else begin
            queue_req(mswb_pkg::REQ_KICK, pick, tmo, 1'($urandom_range(1)));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || holding) @(posedge clock);
      for (guard = 0; guard < 2000 && due_words.size() != 0; guard++) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Run covered %0d requests and %0d result words: %0d expiries,",
               accepted, words_checked, expiries_seen);
      $display("%0d bank-full refusals and %0d bad-slot replies.", fulls_seen, bad_seen);
      if (mismatches == 0 && due_words.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         if (due_words.size() != 0) begin
            $error("%0d expected result words never arrived", due_words.size());
         end
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Hard stop in case the bank hangs.
   initial begin
      #200_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: multi_slot_watchdog_bank.f
+incdir+design
design/mswb_pkg.sv
design/mswb_ctrl.sv
design/mswb_datapath.sv
design/multi_slot_watchdog_bank.sv
sim/tb_top.sv
